### rtl/core/ema_action_filter_with_limits_macros.svh
// ----------------------------------------------------------------------------
// EMA action filter assertion macros
// Shared property forms for the action filter; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef EMA_ACTION_FILTER_WITH_LIMITS_MACROS_SVH
`define EMA_ACTION_FILTER_WITH_LIMITS_MACROS_SVH

// same-cycle implication
`define EAFL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EAFL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/eafl_pkg.sv
// ----------------------------------------------------------------------------
// EMA action filter package
// Field widths, stream packing offsets, codes and fixed-point constants.
// ----------------------------------------------------------------------------
package eafl_pkg;

    localparam int DEFAULT_NUM_JOINTS  = 32;
    localparam int DEFAULT_VALUE_WIDTH = 16;

    localparam int CMD_W    = 2;
    localparam int JOINT_W  = 5;
    localparam int FIELD_W  = 16;
    localparam int SCALE_W  = 16;
    localparam int BLEND_W  = 17;
    localparam int FACTOR_W = 16;
    localparam int U_W      = 22;
    localparam int BETA_W   = 18;

    localparam int IN_TDATA_W  = 72;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 17;

    // input tdata offsets
    localparam int OFF_JOINT  = 0;
    localparam int OFF_ACTION = 5;
    localparam int OFF_LOWER  = 21;
    localparam int OFF_UPPER  = 37;
    localparam int OFF_INIT   = 53;

    // fixed-point shifts
    localparam int U_FRAC    = 20;
    localparam int T_SHIFT   = 21;
    localparam int E_SHIFT   = 16;
    localparam int LD_SHIFT  = 9;
    localparam int MID_SHIFT = 8;

    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 16'd256;
    localparam logic [BLEND_W-1:0]  BLEND_RESET  = 17'd58982;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd256;
    localparam logic [BLEND_W-1:0]  BLEND_ONE    = 17'd65536;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLEND  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FACTOR = 2'd2;

    typedef enum logic [1:0] {
        RUN_NOT_RESET = 2'd0,
        RUN_WAITING   = 2'd1,
        RUN_RUNNING   = 2'd2
    } run_t;

endpackage

### rtl/core/ema_action_filter_with_limits.sv
// ----------------------------------------------------------------------------
// EMA action filter with soft limits
// Per-joint action scaling, soft-limit mapping, EMA blend and clamp.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser carries the command (load
// limits, reset joint value, step action), tdata the joint and operands.
// Every request gives exactly one result on m_axis: tdata is the position,
// tuser holds the accepted and output-valid flags.
// Registers (action scale, blend weight, soft-limit factor) are written on
// the cfg channel, which is always ready; write only while no request is open.
// A request is accepted only in the idle state; one request is in work at a
// time. A reset, rejected or unknown request gives its result from the
// dispatch state, a load from LD_HI after LD_LO, and a step from CLAMP
// after SCALE, SPAN, TGT, PREV and BLEND. The length of the step comes
// from the single registered multiplier, which is used in sequence for
// every product of the step (gain, span, two blend terms).
// The output register lets the next request enter while a result waits; a
// finished request holds its last state until the receiver takes the
// previous result. After reset the registers hold their defaults, the run
// state is not-reset (steps are rejected), and joint tables are undefined
// until loaded and reset. There is no clearing pass.
// ----------------------------------------------------------------------------
`include "ema_action_filter_with_limits_macros.svh"

module ema_action_filter_with_limits #(
    parameter int NUM_JOINTS  = eafl_pkg::DEFAULT_NUM_JOINTS,
    parameter int VALUE_WIDTH = eafl_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // joint[4:0], action[20:5], hard_low[36:21], hard_high[52:37],
    // initial_value[68:53], zero[71:69]
    input  logic [eafl_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // command[1:0]
    input  logic [eafl_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // position[15:0]
    output logic [eafl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // accepted[0], output_valid[1]
    output logic [eafl_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [eafl_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [eafl_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int VW      = VALUE_WIDTH;
    localparam int FW      = eafl_pkg::FIELD_W;
    localparam int JIDX_W  = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int JX_W    = (JIDX_W > eafl_pkg::JOINT_W) ? JIDX_W : eafl_pkg::JOINT_W;
    localparam int A_W     = (VW > FW) ? VW + 1 : FW + 1;
    localparam int B_W     = eafl_pkg::U_W;
    localparam int P_W     = A_W + B_W;
    localparam int ACC_W   = P_W + 2;

    localparam logic signed [ACC_W-1:0] VAL_MAX_A = ACC_W'((64'sd1 <<< (VW - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] VAL_MIN_A = ACC_W'(-(64'sd1 <<< (VW - 1)));
    localparam logic signed [P_W-1:0]   U_MAX     = P_W'(64'sd1 <<< eafl_pkg::U_FRAC);
    localparam logic signed [P_W-1:0]   U_MIN     = P_W'(-(64'sd1 <<< eafl_pkg::U_FRAC));
    localparam logic signed [ACC_W-1:0] HALF_T    = ACC_W'(64'sd1 <<< (eafl_pkg::T_SHIFT - 1));
    localparam logic signed [ACC_W-1:0] HALF_E    = ACC_W'(64'sd1 <<< (eafl_pkg::E_SHIFT - 1));
    localparam logic signed [ACC_W-1:0] HALF_LD   = ACC_W'(64'sd1 <<< (eafl_pkg::LD_SHIFT - 1));

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_DISP  = 10'b0000000010,
        ST_LD_LO = 10'b0000000100,
        ST_LD_HI = 10'b0000001000,
        ST_SCALE = 10'b0000010000,
        ST_SPAN  = 10'b0000100000,
        ST_TGT   = 10'b0001000000,
        ST_PREV  = 10'b0010000000,
        ST_BLEND = 10'b0100000000,
        ST_CLAMP = 10'b1000000000
    } state_t;

    state_t                             state_reg, state_next;
    eafl_pkg::run_t                     run_state_reg, run_state_next;

    logic [eafl_pkg::SCALE_W-1:0]       scale_reg;
    logic [eafl_pkg::BLEND_W-1:0]       blend_reg;
    logic [eafl_pkg::FACTOR_W-1:0]      factor_reg;

    logic [eafl_pkg::CMD_W-1:0]         cmd_reg;
    logic [eafl_pkg::JOINT_W-1:0]       joint_reg;
    logic signed [FW-1:0]               action_reg;
    logic signed [FW-1:0]               lower_reg;
    logic signed [FW-1:0]               upper_reg;
    logic signed [FW-1:0]               init_reg;

    logic signed [P_W-1:0]              prod_reg;
    logic signed [ACC_W-1:0]            acc_reg, acc_next;
    logic signed [B_W-1:0]              u_reg, u_next;
    logic signed [VW:0]                 aux_reg, aux_next;

    logic                               mul_en;
    logic signed [A_W-1:0]              mul_a;
    logic signed [B_W-1:0]              mul_b;
    logic signed [P_W-1:0]              mul_p;

    logic [2*VW-1:0]                    lim_mem [NUM_JOINTS];
    logic [VW-1:0]                      prev_mem [NUM_JOINTS];
    logic [2*VW-1:0]                    lim_rd_reg;
    logic signed [VW-1:0]               prev_rd_reg;
    logic [JX_W-1:0]                    joint_x;
    logic [JIDX_W-1:0]                  mem_idx;
    logic                               lim_we;
    logic [2*VW-1:0]                    lim_wdata;
    logic                               prev_we;
    logic signed [VW-1:0]               prev_wdata;

    logic                               m_axis_tvalid_reg;
    logic [eafl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_reg;
    logic [eafl_pkg::OUT_TUSER_W-1:0]   m_axis_tuser_reg;

    logic                               in_accept;
    logic                               out_free;
    logic                               out_load;
    logic                               res_load;
    logic [eafl_pkg::OUT_TDATA_W-1:0]   res_pos;
    logic                               res_acc;
    logic                               res_ov;

    logic                               joint_ok;
    logic signed [VW-1:0]               sl_val;
    logic signed [VW-1:0]               sh_val;
    logic signed [VW-1:0]               init_sat;
    logic signed [FW:0]                 lim_span;
    logic signed [ACC_W-1:0]            mid_a;
    logic signed [ACC_W-1:0]            lo_sum;
    logic signed [ACC_W-1:0]            hi_sum;
    logic signed [ACC_W-1:0]            t_sum;
    logic signed [ACC_W-1:0]            e_sum;
    logic signed [ACC_W-1:0]            sl_a;
    logic signed [ACC_W-1:0]            sh_a;
    logic signed [ACC_W-1:0]            clamp_lo;
    logic signed [ACC_W-1:0]            clamp_hi;
    logic signed [eafl_pkg::BETA_W-1:0] beta;

    function automatic logic signed [VW-1:0] sat_val(input logic signed [ACC_W-1:0] v);
        logic signed [VW-1:0] r;
        if (v > VAL_MAX_A)
        begin
            r = VAL_MAX_A[VW-1:0];
        end
        else if (v < VAL_MIN_A)
        begin
            r = VAL_MIN_A[VW-1:0];
        end
        else
        begin
            r = v[VW-1:0];
        end
        return r;
    endfunction

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_axis_tvalid_reg;
    assign m_axis_tdata  = m_axis_tdata_reg;
    assign m_axis_tuser  = m_axis_tuser_reg;

    assign out_free = !m_axis_tvalid_reg || m_axis_tready;
    assign out_load = res_load && out_free;

    assign joint_x  = JX_W'(joint_reg);
    assign mem_idx  = joint_x[JIDX_W-1:0];
    assign joint_ok = 32'(joint_reg) < 32'(NUM_JOINTS);

    assign sl_val   = lim_rd_reg[VW-1:0];
    assign sh_val   = lim_rd_reg[2*VW-1:VW];
    assign init_sat = sat_val(ACC_W'(init_reg));
    assign lim_span = (FW + 1)'(upper_reg) - (FW + 1)'(lower_reg);
    assign beta     = signed'(eafl_pkg::BETA_W'(eafl_pkg::BLEND_ONE))
                    - signed'(eafl_pkg::BETA_W'(blend_reg));

    // load: sum of the limits scaled by 256, span product sits in prod_reg
    assign mid_a  = (ACC_W'(lower_reg) + ACC_W'(upper_reg)) <<< eafl_pkg::MID_SHIFT;
    assign lo_sum = mid_a - ACC_W'(prod_reg) + HALF_LD;
    assign hi_sum = mid_a + ACC_W'(prod_reg) + HALF_LD;

    // step: target in soft range, then blend
    assign t_sum = ACC_W'(prod_reg) + (ACC_W'(aux_reg) <<< eafl_pkg::U_FRAC) + HALF_T;
    assign e_sum = acc_reg + ACC_W'(prod_reg) + HALF_E;

    // max against soft_low first, then min against soft_high
    assign sl_a     = ACC_W'(sl_val);
    assign sh_a     = ACC_W'(sh_val);
    assign clamp_lo = (acc_reg < sl_a) ? sl_a : acc_reg;
    assign clamp_hi = (clamp_lo > sh_a) ? sh_a : clamp_lo;

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next     = state_reg;
        run_state_next = run_state_reg;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        u_next         = u_reg;
        aux_next       = aux_reg;
        acc_next       = acc_reg;
        lim_we         = 1'b0;
        lim_wdata      = {sat_val(hi_sum >>> eafl_pkg::LD_SHIFT), aux_reg[VW-1:0]};
        prev_we        = 1'b0;
        prev_wdata     = init_sat;
        res_load       = 1'b0;
        res_pos        = '0;
        res_acc        = 1'b0;
        res_ov         = (run_state_reg == eafl_pkg::RUN_RUNNING);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_DISP;
                end
            end

            ST_DISP:
            begin
                if (joint_ok && cmd_reg == eafl_pkg::CMD_LOAD)
                begin
                    mul_en     = 1'b1;
                    mul_a      = A_W'(lim_span);
                    mul_b      = signed'(B_W'(factor_reg));
                    state_next = ST_LD_LO;
                end
                else if (joint_ok && cmd_reg == eafl_pkg::CMD_RESET)
                begin
                    res_load = 1'b1;
                    res_pos  = eafl_pkg::OUT_TDATA_W'(init_sat);
                    res_acc  = 1'b1;
                    res_ov   = 1'b0;
                    if (out_free)
                    begin
                        prev_we        = 1'b1;
                        run_state_next = eafl_pkg::RUN_WAITING;
                        state_next     = ST_IDLE;
                    end
                end
                else if (joint_ok && cmd_reg == eafl_pkg::CMD_STEP &&
                         run_state_reg != eafl_pkg::RUN_NOT_RESET)
                begin
                    mul_en     = 1'b1;
                    mul_a      = A_W'(action_reg);
                    mul_b      = signed'(B_W'(scale_reg));
                    state_next = ST_SCALE;
                end
                else
                begin
                    // rejected step, unknown command or joint out of range
                    res_load = 1'b1;
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_LD_LO:
            begin
                aux_next   = (VW + 1)'(sat_val(lo_sum >>> eafl_pkg::LD_SHIFT));
                state_next = ST_LD_HI;
            end

            ST_LD_HI:
            begin
                res_load = 1'b1;
                res_acc  = 1'b1;
                if (out_free)
                begin
                    lim_we     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_SCALE:
            begin
                if (prod_reg > U_MAX)
                begin
                    u_next = B_W'(U_MAX);
                end
                else if (prod_reg < U_MIN)
                begin
                    u_next = B_W'(U_MIN);
                end
                else
                begin
                    u_next = B_W'(prod_reg);
                end
                aux_next   = (VW + 1)'(sh_val) - (VW + 1)'(sl_val);
                state_next = ST_SPAN;
            end

            ST_SPAN:
            begin
                mul_en     = 1'b1;
                mul_a      = A_W'(aux_reg);
                mul_b      = u_reg;
                aux_next   = (VW + 1)'(sl_val) + (VW + 1)'(sh_val);
                state_next = ST_TGT;
            end

            ST_TGT:
            begin
                aux_next   = (VW + 1)'(t_sum >>> eafl_pkg::T_SHIFT);
                mul_en     = 1'b1;
                mul_a      = A_W'(prev_rd_reg);
                mul_b      = B_W'(beta);
                state_next = ST_PREV;
            end

            ST_PREV:
            begin
                acc_next   = ACC_W'(prod_reg);
                mul_en     = 1'b1;
                mul_a      = A_W'(aux_reg);
                mul_b      = signed'(B_W'(blend_reg));
                state_next = ST_BLEND;
            end

            ST_BLEND:
            begin
                acc_next   = e_sum >>> eafl_pkg::E_SHIFT;
                state_next = ST_CLAMP;
            end

            ST_CLAMP:
            begin
                prev_wdata = clamp_hi[VW-1:0];
                res_load   = 1'b1;
                res_pos    = eafl_pkg::OUT_TDATA_W'(prev_wdata);
                res_acc    = 1'b1;
                res_ov     = 1'b1;
                if (out_free)
                begin
                    prev_we        = 1'b1;
                    run_state_next = eafl_pkg::RUN_RUNNING;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            run_state_reg     <= eafl_pkg::RUN_NOT_RESET;
            m_axis_tvalid_reg <= 1'b0;
            scale_reg         <= eafl_pkg::SCALE_RESET;
            blend_reg         <= eafl_pkg::BLEND_RESET;
            factor_reg        <= eafl_pkg::FACTOR_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            run_state_reg <= run_state_next;
            if (out_load)
            begin
                m_axis_tvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_axis_tvalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_addr)
                    eafl_pkg::CFG_SCALE:  scale_reg  <= cfg_data[eafl_pkg::SCALE_W-1:0];
                    eafl_pkg::CFG_BLEND:  blend_reg  <= cfg_data;
                    eafl_pkg::CFG_FACTOR: factor_reg <= cfg_data[eafl_pkg::FACTOR_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg    <= s_axis_tuser[eafl_pkg::CMD_W-1:0];
            joint_reg  <= s_axis_tdata[eafl_pkg::OFF_JOINT +: eafl_pkg::JOINT_W];
            action_reg <= s_axis_tdata[eafl_pkg::OFF_ACTION +: FW];
            lower_reg  <= s_axis_tdata[eafl_pkg::OFF_LOWER +: FW];
            upper_reg  <= s_axis_tdata[eafl_pkg::OFF_UPPER +: FW];
            init_reg   <= s_axis_tdata[eafl_pkg::OFF_INIT +: FW];
        end
        if (mul_en)
        begin
            prod_reg <= mul_p;
        end
        u_reg   <= u_next;
        aux_reg <= aux_next;
        acc_reg <= acc_next;
        if (out_load)
        begin
            m_axis_tdata_reg <= res_pos;
            m_axis_tuser_reg <= {res_ov, res_acc};
        end
    end

    // joint tables
    always_ff @(posedge clk)
    begin
        if (lim_we)
        begin
            lim_mem[mem_idx] <= lim_wdata;
        end
        lim_rd_reg <= lim_mem[mem_idx];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[mem_idx] <= prev_wdata;
        end
        prev_rd_reg <= prev_mem[mem_idx];
    end

    `EAFL_ASSERT_NXT(a_accept_to_disp, s_axis_tvalid && s_axis_tready, state_reg == ST_DISP, "accepted request did not reach dispatch")
    `EAFL_ASSERT_IMP(a_ovalid_matches_run, m_axis_tvalid, m_axis_tuser[1] == (run_state_reg == eafl_pkg::RUN_RUNNING), "output_valid flag disagrees with run state")
    `EAFL_ASSERT_IMP(a_step_needs_reset, state_reg == ST_SCALE, run_state_reg != eafl_pkg::RUN_NOT_RESET, "step started before any joint reset")
    `EAFL_ASSERT_IMP(a_prev_write_with_result, prev_we, out_load, "joint value written without a result")

endmodule
